// ===== rtl/rlc_pkg.sv =====
package rlc_pkg;

    localparam int CACHE_DEPTH = 64;
    localparam int IDX_W       = $clog2(CACHE_DEPTH);
    localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);

    localparam logic [2:0] ACT_LOOKUP  = 3'd0;
    localparam logic [2:0] ACT_FILL    = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_COMPACT = 3'd3;
    localparam logic [2:0] ACT_PURGE   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DISABLED = 2'd2;

    localparam logic [0:0] CFG_ENABLE  = 1'd0;
    localparam logic [0:0] CFG_MAX     = 1'd1;

    localparam logic [6:0] MAX_RESET   = 7'd50;

    // Entry record held in the slot memory.
    typedef struct packed {
        logic        kind;
        logic [15:0] key_id;
        logic [31:0] reference;
        logic [15:0] use_count;
        logic [31:0] last_use;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_LOOKUP_WR,
        S_REL_WR,
        S_EVICT_RD,
        S_EVICT_SHIFT,
        S_FILL_DECIDE,
        S_FILL_RD,
        S_FILL_SHIFT,
        S_FILL_WR,
        S_DONE
    } t_state;

endpackage

// ===== rtl/rlc_entry_ram.sv =====
module rlc_entry_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [rlc_pkg::IDX_W-1:0]   i_waddr,
    input  rlc_pkg::t_entry             i_wdata,
    input  logic [rlc_pkg::IDX_W-1:0]   i_raddr,
    output rlc_pkg::t_entry             o_rdata
);
    rlc_pkg::t_entry r_mem [rlc_pkg::CACHE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/refcounted_lru_resource_cache.sv =====
// Reference-counted LRU resource cache.
// Input channel: i_valid / o_stall carry one item (action, key, reference).
// An item is taken when i_valid is high and o_stall is low. Output channel:
// o_valid / i_stall carry one result item per input item.
// Config channel: i_cfg_valid / o_cfg_ready with index 0 caching enable and
// index 1 max entries; write only while idle.
// Entries live in one slot memory, packed front to back, newest at slot 0.
// Lookup, release, compact and a fill that must evict walk the valid slots
// one per cycle through a single read port and one compare unit.
// Compact: a scan, then slots moved one by one to close the gap.
// Fill: an optional eviction pass, then slots moved to open slot 0.
// Purge only clears the entry count.
// The block takes one item at a time; o_stall is high while it works and
// while a result waits. A stalled result holds on the output register.
// Synchronous reset clears the entry count, counters and the access clock;
// the slot memory needs no clearing since only slots below the count are read.
module refcounted_lru_resource_cache (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [2:0]   i_action,
    input  logic         i_res_kind,
    input  logic signed [15:0] i_res_id,
    input  logic [31:0]  i_resource_ref,
    output logic         o_valid,
    input  logic         i_stall,
    output logic         o_hit,
    output logic [31:0]  o_hit_ref,
    output logic         o_release_found,
    output logic         o_evicted,
    output logic [31:0]  o_evicted_ref,
    output logic [1:0]   o_status,
    output logic [6:0]   o_entry_count,
    output logic [31:0]  o_hits_total,
    output logic [31:0]  o_misses_total,
    output logic [31:0]  o_accesses_total,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int IW = rlc_pkg::IDX_W;
    localparam int CW = rlc_pkg::CNT_W;

    rlc_pkg::t_state r_state, n_state;

    logic [2:0]  r_act;
    logic        r_kind;
    logic [15:0] r_id;
    logic [31:0] r_ref;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;          // scan / shift position
    logic [IW-1:0] r_pos;        // matched or chosen slot
    logic        r_found;
    logic [31:0] r_best_use;
    logic [31:0] r_clock;
    logic        r_en;
    logic [6:0]  r_max;
    rlc_pkg::t_entry r_hold;     // entry being modified

    // memory
    logic            w_we;
    logic [IW-1:0]   w_waddr, w_raddr;
    rlc_pkg::t_entry w_wdata, w_rdata;

    rlc_entry_ram u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // The scan pipelines address r_i; data for r_i-1 arrives in S_SCAN.
    // Gap closing writes the slot read into the one before it (r_i-2).
    logic [CW-1:0] w_prev;
    logic [CW-1:0] w_prev2;
    logic          w_key_hit, w_ref_hit, w_evict_cand;
    assign w_prev       = r_i - CW'(1);
    assign w_prev2      = r_i - CW'(2);
    assign w_key_hit    = (w_rdata.kind == r_kind) && (w_rdata.key_id == r_id);
    assign w_ref_hit    = (w_rdata.reference == r_ref);
    assign w_evict_cand = (w_rdata.use_count == 16'd0) &&
                          (!r_found || (w_rdata.last_use < r_best_use));

    logic w_evict_mode;  // scan looking for an eviction victim
    assign w_evict_mode = (r_act == rlc_pkg::ACT_COMPACT) || (r_act == rlc_pkg::ACT_FILL);

    logic w_scan_stop;
    assign w_scan_stop = !w_evict_mode &&
        (((r_act == rlc_pkg::ACT_LOOKUP) && w_key_hit) ||
         ((r_act == rlc_pkg::ACT_RELEASE) && w_ref_hit));

    // Slot contents after a lookup hit (stamp, saturating bump) or a release.
    rlc_pkg::t_entry w_hold_upd;
    always_comb begin
        w_hold_upd = w_rdata;
        if (r_act == rlc_pkg::ACT_LOOKUP) begin
            w_hold_upd.last_use = r_clock + 32'd1;
            if (w_rdata.use_count != 16'hFFFF)
                w_hold_upd.use_count = w_rdata.use_count + 16'd1;
        end else if (w_rdata.use_count != 16'd0) begin
            w_hold_upd.use_count = w_rdata.use_count - 16'd1;
        end
    end

    logic w_cap_full;
    assign w_cap_full = (r_count == CW'(rlc_pkg::CACHE_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlc_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        rlc_pkg::ACT_LOOKUP: n_state = (r_en && r_count != '0) ?
                                             rlc_pkg::S_SCAN_RD : rlc_pkg::S_DONE;
                        rlc_pkg::ACT_RELEASE: n_state = (i_resource_ref != '0 &&
                                             r_count != '0) ? rlc_pkg::S_SCAN_RD
                                             : rlc_pkg::S_DONE;
                        rlc_pkg::ACT_COMPACT: n_state = (r_count != '0) ?
                                             rlc_pkg::S_SCAN_RD : rlc_pkg::S_DONE;
                        rlc_pkg::ACT_FILL: begin
                            if (!r_en || i_resource_ref == '0) begin
                                n_state = rlc_pkg::S_DONE;
                            end else if ({1'b0, r_count} >= {1'b0, CW'(r_max)} &&
                                         r_count != '0) begin
                                n_state = rlc_pkg::S_SCAN_RD;
                            end else begin
                                n_state = rlc_pkg::S_FILL_DECIDE;
                            end
                        end
                        default: n_state = rlc_pkg::S_DONE;
                    endcase
                end
            end
            rlc_pkg::S_SCAN_RD: n_state = rlc_pkg::S_SCAN;
            rlc_pkg::S_SCAN: begin
                if (w_scan_stop) begin
                    n_state = (r_act == rlc_pkg::ACT_LOOKUP) ? rlc_pkg::S_LOOKUP_WR
                              : rlc_pkg::S_REL_WR;
                end else if (r_i == r_count) begin
                    if (!w_evict_mode) begin
                        n_state = rlc_pkg::S_DONE;
                    end else if (r_found || w_evict_cand) begin
                        n_state = rlc_pkg::S_EVICT_RD;
                    end else begin
                        n_state = (r_act == rlc_pkg::ACT_FILL) ?
                                  rlc_pkg::S_FILL_DECIDE : rlc_pkg::S_DONE;
                    end
                end
            end
            rlc_pkg::S_LOOKUP_WR: n_state = rlc_pkg::S_DONE;
            rlc_pkg::S_REL_WR:    n_state = rlc_pkg::S_DONE;
            rlc_pkg::S_EVICT_RD:  n_state = rlc_pkg::S_EVICT_SHIFT;
            rlc_pkg::S_EVICT_SHIFT: begin
                if (r_i >= r_count) begin
                    n_state = (r_act == rlc_pkg::ACT_FILL) ?
                              rlc_pkg::S_FILL_DECIDE : rlc_pkg::S_DONE;
                end else begin
                    n_state = rlc_pkg::S_EVICT_RD;
                end
            end
            rlc_pkg::S_FILL_DECIDE: begin
                if (w_cap_full)          n_state = rlc_pkg::S_DONE;
                else if (r_count == '0)  n_state = rlc_pkg::S_FILL_WR;
                else                     n_state = rlc_pkg::S_FILL_RD;
            end
            rlc_pkg::S_FILL_RD:    n_state = rlc_pkg::S_FILL_SHIFT;
            rlc_pkg::S_FILL_SHIFT: n_state = (r_i == CW'(1)) ? rlc_pkg::S_FILL_WR
                                             : rlc_pkg::S_FILL_RD;
            rlc_pkg::S_FILL_WR:    n_state = rlc_pkg::S_DONE;
            rlc_pkg::S_DONE:       n_state = i_stall ? rlc_pkg::S_DONE : rlc_pkg::S_IDLE;
            default:               n_state = rlc_pkg::S_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_hold;
        w_raddr = r_i[IW-1:0];
        unique case (r_state)
            rlc_pkg::S_SCAN_RD, rlc_pkg::S_SCAN: w_raddr = r_i[IW-1:0];
            rlc_pkg::S_LOOKUP_WR, rlc_pkg::S_REL_WR: w_we = 1'b1;
            rlc_pkg::S_EVICT_RD: w_raddr = r_i[IW-1:0];
            rlc_pkg::S_EVICT_SHIFT: begin
                w_we    = (w_prev < r_count);
                w_waddr = w_prev2[IW-1:0];
                w_wdata = w_rdata;
            end
            rlc_pkg::S_FILL_RD: w_raddr = w_prev[IW-1:0];
            rlc_pkg::S_FILL_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_i[IW-1:0];
                w_wdata = w_rdata;
            end
            rlc_pkg::S_FILL_WR: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{kind: r_kind, key_id: r_id, reference: r_ref,
                            use_count: 16'd1, last_use: r_clock};
            end
            default: ;
        endcase
    end

    assign o_stall     = (r_state != rlc_pkg::S_IDLE);
    assign o_valid     = (r_state == rlc_pkg::S_DONE);
    assign o_cfg_ready = (r_state == rlc_pkg::S_IDLE);
    assign o_entry_count = 7'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlc_pkg::S_IDLE;
            r_count <= '0;
            r_clock <= '0;
            r_en    <= 1'b1;
            r_max   <= rlc_pkg::MAX_RESET;
            o_hits_total     <= '0;
            o_misses_total   <= '0;
            o_accesses_total <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == rlc_pkg::CFG_ENABLE) r_en <= i_cfg_data[0];
                else r_max <= i_cfg_data[6:0];
            end
            unique case (r_state)
                rlc_pkg::S_IDLE: begin
                    if (i_valid) begin
                        if (i_action == rlc_pkg::ACT_LOOKUP) begin
                            o_accesses_total <= o_accesses_total + 32'd1;
                            if (!(r_en && r_count != '0)) begin
                                o_misses_total <= o_misses_total + 32'd1;
                            end
                        end
                        if (i_action == rlc_pkg::ACT_PURGE) r_count <= '0;
                    end
                end
                rlc_pkg::S_SCAN: begin
                    if (r_act == rlc_pkg::ACT_LOOKUP && !w_scan_stop && r_i == r_count) begin
                        o_misses_total <= o_misses_total + 32'd1;
                    end
                end
                rlc_pkg::S_LOOKUP_WR: begin
                    r_clock <= r_clock + 32'd1;
                    o_hits_total <= o_hits_total + 32'd1;
                end
                rlc_pkg::S_EVICT_SHIFT: begin
                    if (r_i >= r_count) r_count <= r_count - CW'(1);
                end
                rlc_pkg::S_FILL_DECIDE: begin
                    if (!w_cap_full) r_clock <= r_clock + 32'd1;
                end
                rlc_pkg::S_FILL_WR: r_count <= r_count + CW'(1);
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rlc_pkg::S_IDLE: begin
                r_act   <= i_action;
                r_kind  <= i_res_kind;
                r_id    <= i_res_id;
                r_ref   <= i_resource_ref;
                r_i     <= '0;
                r_found <= 1'b0;
                o_hit   <= 1'b0;
                o_hit_ref <= '0;
                o_release_found <= 1'b0;
                o_evicted <= 1'b0;
                o_evicted_ref <= '0;
                o_status <= (i_action == rlc_pkg::ACT_FILL && !r_en) ?
                            rlc_pkg::ST_DISABLED : rlc_pkg::ST_OK;
            end
            rlc_pkg::S_SCAN_RD: r_i <= r_i + CW'(1);
            rlc_pkg::S_SCAN: begin
                if (w_scan_stop) begin
                    r_pos  <= w_prev[IW-1:0];
                    r_hold <= w_hold_upd;
                    if (r_act == rlc_pkg::ACT_LOOKUP) begin
                        o_hit     <= 1'b1;
                        o_hit_ref <= w_rdata.reference;
                    end else begin
                        o_release_found <= 1'b1;
                    end
                end else if (w_evict_mode && w_evict_cand) begin
                    r_found    <= 1'b1;
                    r_pos      <= w_prev[IW-1:0];
                    r_best_use <= w_rdata.last_use;
                    o_evicted_ref <= w_rdata.reference;
                end
                if (r_i == r_count && (r_found || (w_evict_mode && w_evict_cand))) begin
                    o_evicted <= 1'b1;
                    // gap closing reads slot pos+1 onward
                    r_i <= (w_evict_mode && w_evict_cand) ? r_i : CW'(r_pos) + CW'(1);
                end else begin
                    r_i <= r_i + CW'(1);
                end
            end
            rlc_pkg::S_EVICT_RD: r_i <= r_i + CW'(1);
            rlc_pkg::S_EVICT_SHIFT: ;
            rlc_pkg::S_FILL_DECIDE: r_i <= r_count;
            rlc_pkg::S_FILL_SHIFT: r_i <= r_i - CW'(1);
            rlc_pkg::S_DONE: ;
            default: ;
        endcase
        if (r_state == rlc_pkg::S_FILL_DECIDE && w_cap_full) o_status <= rlc_pkg::ST_FULL;
    end

endmodule

// ===== test/refcounted_lru_resource_cache_tb.sv =====
`timescale 1ns / 100ps

module refcounted_lru_resource_cache_tb;

    // Input row: fields of one item; a t_row around it may carry a fixed expected result.
    typedef struct packed {
        logic [2:0]  action;
        logic        kind;
        logic [15:0] id;
        logic [31:0] ref_val;
    } t_item;

    // Result of one item.
    typedef struct packed {
        logic        hit;
        logic [31:0] hit_ref;
        logic        rel_found;
        logic        evicted;
        logic [31:0] ev_ref;
        logic [1:0]  status;
        logic [6:0]  count;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] accesses;
    } t_result;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    logic [2:0]   action;
    logic         res_kind;
    logic [15:0]  res_id;
    logic [31:0]  resource_ref;
    logic         out_valid;
    logic         out_stall;
    logic         hit;
    logic [31:0]  hit_ref;
    logic         release_found;
    logic         evicted;
    logic [31:0]  evicted_ref;
    logic [1:0]   status;
    logic [6:0]   entry_count;
    logic [31:0]  hits_total;
    logic [31:0]  misses_total;
    logic [31:0]  accesses_total;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    refcounted_lru_resource_cache dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_action         (action),
        .i_res_kind       (res_kind),
        .i_res_id         (res_id),
        .i_resource_ref   (resource_ref),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_hit            (hit),
        .o_hit_ref        (hit_ref),
        .o_release_found  (release_found),
        .o_evicted        (evicted),
        .o_evicted_ref    (evicted_ref),
        .o_status         (status),
        .o_entry_count    (entry_count),
        .o_hits_total     (hits_total),
        .o_misses_total   (misses_total),
        .o_accesses_total (accesses_total),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Shadow copy of the directory, packed newest first like the block.
    logic        sh_kind  [rlc_pkg::CACHE_DEPTH];
    logic [15:0] sh_id    [rlc_pkg::CACHE_DEPTH];
    logic [31:0] sh_ref   [rlc_pkg::CACHE_DEPTH];
    logic [15:0] sh_uses  [rlc_pkg::CACHE_DEPTH];
    logic [31:0] sh_stamp [rlc_pkg::CACHE_DEPTH];
    int          sh_count;
    logic [31:0] sh_clock;
    logic [31:0] sh_hits;
    logic [31:0] sh_misses;
    logic [31:0] sh_accesses;
    logic        sh_enable;
    logic [6:0]  sh_max;

    t_result pending_results[$];
    int      fail_count;
    // Stall knob for the result side; 0 turns off the short stalls, rare long ones remain.
    int      stall_pct;
    // Refs recently filled, reused so that releases actually find them.
    logic [31:0] ref_pool[$];

    task automatic reset_model();
        sh_count    = 0;
        sh_clock    = '0;
        sh_hits     = '0;
        sh_misses   = '0;
        sh_accesses = '0;
        sh_enable   = 1'b1;
        sh_max      = rlc_pkg::MAX_RESET;
    endtask

    task automatic drop_slot(input int p);
        for (int i = p; i + 1 < sh_count; i++) begin
            sh_kind[i]  = sh_kind[i+1];
            sh_id[i]    = sh_id[i+1];
            sh_ref[i]   = sh_ref[i+1];
            sh_uses[i]  = sh_uses[i+1];
            sh_stamp[i] = sh_stamp[i+1];
        end
        sh_count--;
    endtask

    // Oldest entry with no users goes; ties favor the front.
    task automatic evict_oldest(output logic found, output logic [31:0] victim);
        int best;
        best   = -1;
        found  = 1'b0;
        victim = '0;
        for (int i = 0; i < sh_count; i++) begin
            if (sh_uses[i] == 0 && (best < 0 || sh_stamp[i] < sh_stamp[best]))
                best = i;
        end
        if (best >= 0) begin
            found  = 1'b1;
            victim = sh_ref[best];
            drop_slot(best);
        end
    endtask

    task automatic predict_cache(input t_item it, output t_result r);
        logic        f;
        logic [31:0] v;
        r = '{default: '0};
        case (it.action)
            rlc_pkg::ACT_LOOKUP: begin
                sh_accesses++;
                if (sh_enable) begin
                    for (int i = 0; i < sh_count; i++) begin
                        if (sh_kind[i] == it.kind && sh_id[i] == it.id) begin
                            sh_clock++;
                            sh_stamp[i] = sh_clock;
                            if (sh_uses[i] != 16'hFFFF) sh_uses[i]++;
                            r.hit     = 1'b1;
                            r.hit_ref = sh_ref[i];
                            break;
                        end
                    end
                end
                if (r.hit) sh_hits++;
                else sh_misses++;
            end
            rlc_pkg::ACT_FILL: begin
                if (!sh_enable) begin
                    r.status = rlc_pkg::ST_DISABLED;
                end else if (it.ref_val != 0) begin
                    if (sh_count >= sh_max) begin
                        evict_oldest(f, v);
                        r.evicted = f;
                        r.ev_ref  = v;
                    end
                    if (sh_count >= rlc_pkg::CACHE_DEPTH) begin
                        r.status = rlc_pkg::ST_FULL;
                    end else begin
                        for (int i = sh_count; i > 0; i--) begin
                            sh_kind[i]  = sh_kind[i-1];
                            sh_id[i]    = sh_id[i-1];
                            sh_ref[i]   = sh_ref[i-1];
                            sh_uses[i]  = sh_uses[i-1];
                            sh_stamp[i] = sh_stamp[i-1];
                        end
                        sh_clock++;
                        sh_kind[0]  = it.kind;
                        sh_id[0]    = it.id;
                        sh_ref[0]   = it.ref_val;
                        sh_uses[0]  = 16'd1;
                        sh_stamp[0] = sh_clock;
                        sh_count++;
                    end
                end
            end
            rlc_pkg::ACT_RELEASE: begin
                if (it.ref_val != 0) begin
                    for (int i = 0; i < sh_count; i++) begin
                        if (sh_ref[i] == it.ref_val) begin
                            if (sh_uses[i] != 0) sh_uses[i]--;
                            r.rel_found = 1'b1;
                            break;
                        end
                    end
                end
            end
            rlc_pkg::ACT_COMPACT: begin
                evict_oldest(f, v);
                r.evicted = f;
                r.ev_ref  = v;
            end
            rlc_pkg::ACT_PURGE: sh_count = 0;
            default: ;
        endcase
        r.count    = 7'(sh_count);
        r.hits     = sh_hits;
        r.misses   = sh_misses;
        r.accesses = sh_accesses;
    endtask

    // Field-by-field compare against the oldest expectation.
    always @(posedge clk) begin
        t_result e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (hit !== e.hit || hit_ref !== e.hit_ref || release_found !== e.rel_found
                        || evicted !== e.evicted || evicted_ref !== e.ev_ref
                        || status !== e.status || entry_count !== e.count
                        || hits_total !== e.hits || misses_total !== e.misses
                        || accesses_total !== e.accesses) begin
                    $display("%0t: mismatch exp hit=%b ref=%h rel=%b ev=%b evref=%h st=%0d cnt=%0d h=%0d m=%0d a=%0d",
                             $time, e.hit, e.hit_ref, e.rel_found, e.evicted, e.ev_ref,
                             e.status, e.count, e.hits, e.misses, e.accesses);
                    $display("%0t:          act hit=%b ref=%h rel=%b ev=%b evref=%h st=%0d cnt=%0d h=%0d m=%0d a=%0d",
                             $time, hit, hit_ref, release_found, evicted, evicted_ref,
                             status, entry_count, hits_total, misses_total, accesses_total);
                    fail_count++;
                end
            end
        end
    end

    // Mostly short stalls, now and then a long one.
    always @(negedge clk) begin
        if ($urandom_range(499) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(60, 20)) @(negedge clk);
            out_stall <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input t_item it, output t_result r);
        int gap;
        gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
        if ($urandom_range(3) == 0) gap = 0;
        // valid dropped at the last negedge; drive the next item after the random gap
        repeat (gap + 1) @(negedge clk);
        action       <= it.action;
        res_kind     <= it.kind;
        res_id       <= it.id;
        resource_ref <= it.ref_val;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_cache(it, r);
        pending_results.push_back(r);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(negedge clk);
        // the block may still be finishing its final item internally
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == rlc_pkg::CFG_ENABLE) sh_enable = val[0];
        else sh_max = val[6:0];
    endtask

    // Mostly well-formed traffic around a small key space so hits are common.
    function automatic t_item random_item();
        t_item it;
        int    sel;
        sel        = $urandom_range(99);
        it.kind    = 1'($urandom_range(1));
        it.id      = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12));
        it.ref_val = 32'($urandom);
        if (sel < 35) it.action = rlc_pkg::ACT_LOOKUP;
        else if (sel < 65) it.action = rlc_pkg::ACT_FILL;
        else if (sel < 87) it.action = rlc_pkg::ACT_RELEASE;
        else if (sel < 95) it.action = rlc_pkg::ACT_COMPACT;
        else if (sel < 97) it.action = rlc_pkg::ACT_PURGE;
        else it.action = 3'($urandom_range(7, 5));
        if (it.action == rlc_pkg::ACT_RELEASE && ref_pool.size() != 0 &&
                $urandom_range(4) != 0)
            it.ref_val = ref_pool[$urandom_range(ref_pool.size() - 1)];
        if ($urandom_range(30) == 0) it.ref_val = '0;
        return it;
    endfunction

    task automatic run_random(input int n);
        t_item   it;
        t_result r;
        for (int k = 0; k < n; k++) begin
            it = random_item();
            if (it.action == rlc_pkg::ACT_FILL && it.ref_val != 0) begin
                ref_pool.push_back(it.ref_val);
                if (ref_pool.size() > 40) void'(ref_pool.pop_front());
            end
            send_item(it, r);
            // halfway through, let everything drain before the next item
            if (k == n / 2) while (pending_results.size() != 0) @(negedge clk);
        end
    endtask

    // Directed rows; fixed expectations where obvious, else predictor only.
    typedef struct {
        t_item   it;
        logic    fixed;
        t_result exp;
    } t_row;

    t_row directed[$];

    initial begin
        t_result r;
        in_valid     = 1'b0;
        action       = '0;
        res_kind     = 1'b0;
        res_id       = '0;
        resource_ref = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        stall_pct    = 0;
        fail_count   = 0;
        rst_n        = 1'b0;
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // lookup on empty cache, release and compact on empty, null fill
        directed.push_back('{'{rlc_pkg::ACT_LOOKUP, 1'b0, 16'h0000, 32'h0}, 1'b1,
                            '{0, 0, 0, 0, 0, rlc_pkg::ST_OK, 0, 0, 1, 1}});
        directed.push_back('{'{rlc_pkg::ACT_RELEASE, 1'b1, 16'h7FFF, 32'hFFFF_FFFF}, 1'b1,
                            '{0, 0, 0, 0, 0, rlc_pkg::ST_OK, 0, 0, 1, 1}});
        directed.push_back('{'{rlc_pkg::ACT_COMPACT, 1'b0, 16'h8000, 32'h0}, 1'b1,
                            '{0, 0, 0, 0, 0, rlc_pkg::ST_OK, 0, 0, 1, 1}});
        directed.push_back('{'{rlc_pkg::ACT_FILL, 1'b1, 16'h8000, 32'h0}, 1'b1,
                            '{0, 0, 0, 0, 0, rlc_pkg::ST_OK, 0, 0, 1, 1}});
        directed.push_back('{'{rlc_pkg::ACT_FILL, 1'b1, 16'h8000, 32'hFFFF_FFFF}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_FILL, 1'b0, 16'h7FFF, 32'h0000_0001}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_FILL, 1'b0, 16'h7FFF, 32'hA5A5_5A5A}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_LOOKUP, 1'b0, 16'h7FFF, 32'h0}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_LOOKUP, 1'b1, 16'h8000, 32'h0}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_LOOKUP, 1'b1, 16'h7FFF, 32'h0}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_RELEASE, 1'b0, 16'h0, 32'h0}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_RELEASE, 1'b0, 16'h0, 32'h0000_0001}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_RELEASE, 1'b0, 16'h0, 32'h0000_0001}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_COMPACT, 1'b0, 16'h0, 32'h0}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{3'd5, 1'b1, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '{default: '0}});
        directed.push_back('{'{3'd7, 1'b0, 16'h0, 32'h0}, 1'b0, '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_PURGE, 1'b0, 16'h0, 32'h0}, 1'b0,
                            '{default: '0}});
        directed.push_back('{'{rlc_pkg::ACT_LOOKUP, 1'b1, 16'h8000, 32'h0}, 1'b0,
                            '{default: '0}});

        foreach (directed[i]) begin
            send_item(directed[i].it, r);
            if (directed[i].fixed && r !== directed[i].exp) begin
                $display("%0t: directed row %0d exp %h act %h",
                         $time, i, directed[i].exp, r);
                fail_count++;
            end
        end
        wait_drain();

        // Caching off: lookups miss, fills ignored; cache not purged.
        write_reg(rlc_pkg::CFG_ENABLE, 32'h0);
        stall_pct = 30;
        run_random(60);
        wait_drain();
        write_reg(rlc_pkg::CFG_ENABLE, 32'h1);

        // Limit of zero: every fill with a nonzero ref on a non-empty cache tries an eviction first.
        write_reg(rlc_pkg::CFG_MAX, 32'h0);
        run_random(120);
        wait_drain();

        // Small limit with heavy churn.
        write_reg(rlc_pkg::CFG_MAX, 32'h3);
        stall_pct = 10;
        run_random(200);
        wait_drain();

        // Limit above the store: fill the store to hit the full-drop case.
        write_reg(rlc_pkg::CFG_MAX, 32'h7F);
        stall_pct = 0;
        begin
            t_item it;
            for (int k = 0; k < 70; k++) begin
                it = '{rlc_pkg::ACT_FILL, 1'($urandom_range(1)), 16'($urandom),
                       32'($urandom) | 32'h1};
                send_item(it, r);
            end
            // release some so compaction and eviction have candidates
            for (int k = 0; k < 10; k++) begin
                it = '{rlc_pkg::ACT_RELEASE, 1'b0, 16'h0,
                       sh_ref[$urandom_range(sh_count - 1)]};
                send_item(it, r);
            end
            for (int k = 0; k < 15; k++) begin
                it = '{rlc_pkg::ACT_FILL, 1'b0, 16'($urandom), 32'($urandom) | 32'h1};
                send_item(it, r);
            end
        end
        wait_drain();

        write_reg(rlc_pkg::CFG_MAX, 32'd64);
        stall_pct = 20;
        run_random(200);
        wait_drain();

        write_reg(rlc_pkg::CFG_MAX, 32'($urandom_range(20, 4)));
        stall_pct = 15;
        run_random(220);
        wait_drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
